// File: rtl/vgcc_pkg.sv
// vgcc_pkg: shared types and constants for the voice gated clip capture block
// request and result payloads, config image, controller/datapath command and status
// no dependencies
package vgcc_pkg;

	// request kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	// config port address width (three 32-bit registers at 4*i)
	localparam int APB_AW = 4;

	// one request
	typedef struct packed {
		logic               kind;
		logic signed [15:0] sample;
		logic               speech;
		logic               frame_last;
		logic [9:0]         frame_ms;
		logic [31:0]        now_ms;
		logic               armed;
		logic               link_up;
		logic [14:0]        read_index;
	} in_t;

	// one result
	typedef struct packed {
		logic               clip_ready;
		logic [15:0]        clip_length;
		logic               capturing;
		logic signed [15:0] read_data;
	} out_t;

	// register image
	typedef struct packed {
		logic [15:0] cooldown_ms;
		logic [15:0] min_speech_ms;
		logic [15:0] end_silence_ms;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic start;
		logic copy;
		logic clip_rd;
		logic idle_frame;
		logic sample;
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic kind;
		logic armed;
		logic start_ok;
		logic copy_done;
	} stat_t;

endpackage

// File: rtl/vgcc_regs.sv
// vgcc_regs: configuration registers behind the apb-style port
// depends on vgcc_pkg
module vgcc_regs
	import vgcc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cfg_t              cfg
);

	localparam logic [1:0] REG_COOLDOWN    = 2'd0;
	localparam logic [1:0] REG_MIN_SPEECH  = 2'd1;
	localparam logic [1:0] REG_END_SILENCE = 2'd2;

	localparam logic [15:0] COOLDOWN_RST    = 16'd3000;
	localparam logic [15:0] MIN_SPEECH_RST  = 16'd300;
	localparam logic [15:0] END_SILENCE_RST = 16'd350;

	logic [1:0] reg_sel;
	logic       wr_en;
	cfg_t       cfg_q;

	assign reg_sel = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cooldown_ms    <= COOLDOWN_RST;
			cfg_q.min_speech_ms  <= MIN_SPEECH_RST;
			cfg_q.end_silence_ms <= END_SILENCE_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_COOLDOWN:    cfg_q.cooldown_ms    <= pwdata[15:0];
				REG_MIN_SPEECH:  cfg_q.min_speech_ms  <= pwdata[15:0];
				REG_END_SILENCE: cfg_q.end_silence_ms <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_sel)
			REG_COOLDOWN:    prdata = {16'd0, cfg_q.cooldown_ms};
			REG_MIN_SPEECH:  prdata = {16'd0, cfg_q.min_speech_ms};
			REG_END_SILENCE: prdata = {16'd0, cfg_q.end_silence_ms};
			default:         prdata = 32'd0;
		endcase
	end

endmodule

// File: rtl/vgcc_ctrl.sv
// vgcc_ctrl: sequencing state machine and result valid flag
// depends on vgcc_pkg; drives the datapath through cmd_t, reads stat_t
module vgcc_ctrl
	import vgcc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  src_valid,
	output logic  src_ready,
	output logic  dst_valid,
	input  logic  dst_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECIDE = 3'd1;
	localparam logic [2:0] S_COPY   = 3'd2;
	localparam logic [2:0] S_SAMPLE = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign src_ready = (state_q == S_IDLE);
	assign dst_valid = out_valid_q;
	assign out_free  = !out_valid_q || dst_ready;

	// next state and commands
	always_comb begin
		state_nxt      = state_q;
		cmd            = '0;
		cmd.latch      = src_valid && src_ready;
		unique case (state_q)
			S_IDLE: begin
				if (src_valid)
					state_nxt = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.kind == KIND_READ) begin
					cmd.clip_rd = 1'b1;
					state_nxt   = S_DONE;
				end else if (!stat.armed) begin
					cmd.idle_frame = 1'b1;
					state_nxt      = S_DONE;
				end else if (stat.start_ok) begin
					cmd.start = 1'b1;
					state_nxt = S_COPY;
				end else begin
					state_nxt = S_SAMPLE;
				end
			end
			S_COPY: begin
				cmd.copy = 1'b1;
				if (stat.copy_done)
					state_nxt = S_SAMPLE;
			end
			S_SAMPLE: begin
				cmd.sample = 1'b1;
				state_nxt  = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	// state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (dst_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

// File: rtl/vgcc_dp.sv
// vgcc_dp: capture datapath with pre-roll ring, clip store, timing checks
// depends on vgcc_pkg; commanded by vgcc_ctrl
module vgcc_dp
	import vgcc_pkg::*;
#(
	parameter int PRE_SAMPLES  = 2048,
	parameter int CLIP_SAMPLES = 32768
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  in_t  src_data,
	input  cmd_t cmd,
	output stat_t stat,
	output out_t out_data
);

	localparam int PAW    = $clog2(PRE_SAMPLES);
	localparam int CAW    = $clog2(CLIP_SAMPLES);
	localparam int FW     = $clog2(CLIP_SAMPLES + 1);
	localparam int COPY_N = (PRE_SAMPLES < CLIP_SAMPLES) ? PRE_SAMPLES : CLIP_SAMPLES;
	localparam int CNW    = $clog2(COPY_N + 1);

	localparam logic [PAW-1:0] POS_LAST = PAW'(PRE_SAMPLES - 1);
	localparam logic [FW-1:0]  FILL_MAX = FW'(CLIP_SAMPLES);
	localparam logic [CNW-1:0] COPY_LEN = CNW'(COPY_N);

	// storage
	logic [15:0] ring_mem [PRE_SAMPLES];
	logic [15:0] clip_mem [CLIP_SAMPLES];

	// control state
	in_t            item_q;
	logic [PAW-1:0] pos_q;
	logic           wrapped_q;
	logic [FW-1:0]  fill_q;
	logic           active_q;
	logic [15:0]    voiced_q;
	logic [31:0]    last_voice_q;
	logic [31:0]    last_sent_q;
	logic           at_start_q;

	// copy pipe
	logic [PAW-1:0] cp_idx_q;
	logic [CNW-1:0] cp_cnt_q;
	logic           cp_v_s1;
	logic           cp_zero_s1;
	logic [15:0]    cp_data_s1;

	// read-back and result
	logic [15:0] clip_rd_s1;
	logic        rd_inr_s1;
	logic        res_ready_q;
	logic [15:0] res_len_q;
	out_t        out_q;

	logic [PAW-1:0] pos_nxt;
	logic [PAW-1:0] cp_idx_nxt;
	logic           copy_rd;
	logic           smp_clip_wr;
	logic           clip_we;
	logic [CAW-1:0] clip_wa;
	logic [15:0]    clip_wd;
	logic [CAW-1:0] clip_ra;
	logic [FW-1:0]  fill_inc;
	logic [FW-1:0]  fill_after;
	logic [16:0]    voiced_sum;
	logic [15:0]    voiced_sat;
	logic [15:0]    voiced_after;
	logic [31:0]    cool_gap;
	logic [31:0]    quiet_gap;
	logic           frame_end;
	logic           full;
	logic           ended;
	logic           close;
	logic           qualify;

	// ring pointers
	assign pos_nxt    = (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
	assign cp_idx_nxt = (cp_idx_q == POS_LAST) ? '0 : cp_idx_q + 1'b1;

	// start check: first sample of a voiced frame outside the cooldown
	assign cool_gap      = item_q.now_ms - last_sent_q;
	assign stat.kind     = item_q.kind;
	assign stat.armed    = item_q.armed;
	assign stat.start_ok = !active_q && at_start_q && item_q.speech
		&& (cool_gap > 32'(cfg.cooldown_ms));
	assign stat.copy_done = (cp_cnt_q == COPY_LEN) && !cp_v_s1;

	// clip write port, shared by pre-roll copy and live samples
	assign copy_rd     = cmd.copy && (cp_cnt_q != COPY_LEN);
	assign smp_clip_wr = cmd.sample && active_q && (fill_q < FILL_MAX);
	assign clip_we     = cp_v_s1 || smp_clip_wr;
	assign clip_wa     = fill_q[CAW-1:0];
	assign clip_wd     = cp_v_s1 ? (cp_zero_s1 ? 16'd0 : cp_data_s1) : item_q.sample;
	assign clip_ra     = CAW'(item_q.read_index);
	assign fill_inc    = fill_q + 1'b1;
	assign fill_after  = smp_clip_wr ? fill_inc : fill_q;

	// frame-end checks
	assign voiced_sum   = {1'b0, voiced_q} + 17'(item_q.frame_ms);
	assign voiced_sat   = voiced_sum[16] ? 16'hFFFF : voiced_sum[15:0];
	assign voiced_after = item_q.speech ? voiced_sat : voiced_q;
	assign quiet_gap    = item_q.now_ms - last_voice_q;
	assign frame_end    = active_q && item_q.frame_last;
	assign full         = fill_after >= FILL_MAX;
	assign ended        = !item_q.speech && (voiced_after != 16'd0)
		&& (quiet_gap > 32'(cfg.end_silence_ms));
	assign close        = frame_end && (full || ended);
	assign qualify      = (voiced_after >= cfg.min_speech_ms) && item_q.link_up;

	// pre-roll ring
	always_ff @(posedge clk) begin
		if (cmd.sample)
			ring_mem[pos_q] <= item_q.sample;
		if (copy_rd)
			cp_data_s1 <= ring_mem[cp_idx_q];
	end

	// clip store
	always_ff @(posedge clk) begin
		if (clip_we)
			clip_mem[clip_wa] <= clip_wd;
		if (cmd.clip_rd)
			clip_rd_s1 <= clip_mem[clip_ra];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			wrapped_q    <= 1'b0;
			fill_q       <= '0;
			active_q     <= 1'b0;
			voiced_q     <= 16'd0;
			last_voice_q <= 32'd0;
			last_sent_q  <= 32'd0;
			at_start_q   <= 1'b1;
			cp_cnt_q     <= '0;
			cp_v_s1      <= 1'b0;
		end else begin
			// capture start and copy sequencing
			if (cmd.start) begin
				active_q <= 1'b1;
				voiced_q <= 16'd0;
				cp_cnt_q <= '0;
				cp_v_s1  <= 1'b0;
			end else if (cmd.copy) begin
				cp_v_s1 <= copy_rd;
				if (copy_rd)
					cp_cnt_q <= cp_cnt_q + 1'b1;
			end

			// fill count follows clip writes
			if (cmd.start)
				fill_q <= '0;
			else if (clip_we)
				fill_q <= fill_inc;

			// live sample
			if (cmd.sample) begin
				pos_q <= pos_nxt;
				if (pos_q == POS_LAST)
					wrapped_q <= 1'b1;
				if (frame_end)
					voiced_q <= voiced_after;
				if (frame_end && item_q.speech)
					last_voice_q <= item_q.now_ms;
				if (close)
					active_q <= 1'b0;
				if (close && qualify)
					last_sent_q <= item_q.now_ms;
			end

			if (cmd.sample || cmd.idle_frame)
				at_start_q <= item_q.frame_last;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q      <= src_data;
			res_ready_q <= 1'b0;
			res_len_q   <= 16'd0;
		end else if (cmd.sample && close && qualify) begin
			res_ready_q <= 1'b1;
			res_len_q   <= 16'(fill_after);
		end

		// copy reads oldest first; entries never written read as zero
		if (cmd.start)
			cp_idx_q <= pos_q;
		else if (copy_rd)
			cp_idx_q <= cp_idx_nxt;
		if (copy_rd)
			cp_zero_s1 <= !(wrapped_q || (cp_idx_q < pos_q));

		if (cmd.clip_rd)
			rd_inr_s1 <= 32'(item_q.read_index) < 32'(CLIP_SAMPLES);

		if (cmd.load_out) begin
			out_q.clip_ready  <= res_ready_q;
			out_q.clip_length <= res_len_q;
			out_q.capturing   <= active_q;
			out_q.read_data   <= (item_q.kind == KIND_READ && rd_inr_s1) ? clip_rd_s1 : 16'd0;
		end
	end

	assign out_data = out_q;

endmodule

// File: rtl/voice_gated_clip_capture.sv
// voice_gated_clip_capture: top level of the voice gated clip capture block
// depends on vgcc_pkg, vgcc_regs, vgcc_ctrl, vgcc_dp
//
//  channel   dir   handshake             payload
//  src       in    src_valid/src_ready   src_data (in_t)
//  dst       out   dst_valid/dst_ready   dst_data (out_t)
//  config    in    psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// an armed sample request steps through accept, decide, sample update, result load
// a request that starts a capture adds a pre-roll copy of min(PRE_SAMPLES, CLIP_SAMPLES)
// words before the sample update, one word a cycle through the single clip write port;
// then the ring read stage drains and the copy is seen done
// clip reads and disarmed samples skip the sample update: accept, decide, result load
// arst_n clears the sequencer and datapath control registers; the pre-roll ring needs no
// clearing pass, unwritten entries are tracked by the ring position and a wrap flag
// a new request is taken while the previous result still waits on dst_ready
module voice_gated_clip_capture
	import vgcc_pkg::*;
#(
	parameter int PRE_SAMPLES  = 2048,
	parameter int CLIP_SAMPLES = 32768
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_ready,
	input  in_t               src_data,
	output logic              dst_valid,
	input  logic              dst_ready,
	output out_t              dst_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	// configuration registers
	vgcc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	vgcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath
	vgcc_dp #(
		.PRE_SAMPLES  (PRE_SAMPLES),
		.CLIP_SAMPLES (CLIP_SAMPLES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.src_data (src_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (dst_data)
	);

`ifndef SYNTHESIS
	// one request in flight: no accept in the cycle after an accept
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		src_valid && src_ready |=> !src_ready)
		else $error("request accepted while previous one in flight");

	// copy and live sample update never overlap on the clip write port
	a_port_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.copy && cmd.sample))
		else $error("copy and sample commands overlap");

	// a new result only appears after a load command
	a_load_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dst_valid) |-> $past(cmd.load_out))
		else $error("result valid without load");

	// a reported clip has ended its capture
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && dst_data.clip_ready |-> !dst_data.capturing)
		else $error("clip reported while still capturing");

	// read data and clip report never come from the same request
	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		dst_valid && (dst_data.read_data != 16'd0) |->
			!dst_data.clip_ready && (dst_data.clip_length == 16'd0))
		else $error("read data mixed with clip report");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for voice_gated_clip_capture, a predictor runs beside the block
// depends on vgcc_pkg and the voice_gated_clip_capture rtl, nothing else
module tb;
	import vgcc_pkg::*;

	localparam int PRE_N  = 2048;
	localparam int CLIP_N = 32768;
	localparam int LIMIT  = 20000000;

	// register indexes on the config port
	localparam int REG_COOLDOWN    = 0;
	localparam int REG_MIN_SPEECH  = 1;
	localparam int REG_END_SILENCE = 2;

	localparam out_t NO_RESULT = '0;
	localparam out_t CAP_ON    = {1'b0, 16'h0000, 1'b1, 16'h0000};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              src_valid;
	logic              src_ready;
	in_t               src_data;
	logic              dst_valid;
	logic              dst_ready;
	out_t              dst_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	voice_gated_clip_capture u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.dst_valid (dst_valid),
		.dst_ready (dst_ready),
		.dst_data  (dst_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [15:0] pre_ring [PRE_N];
	logic [15:0] clip_mem [CLIP_N];
	int unsigned ring_wr     = 0;
	int unsigned fill        = 0;
	int unsigned clip_hi     = 0;
	int unsigned speech_acc  = 0;
	bit          cap_on      = 1'b0;
	bit          frame_start = 1'b1;
	logic [31:0] last_voiced_at = '0;
	logic [31:0] last_sent_at   = '0;
	logic [15:0] cfg_cooldown    = 16'd3000;
	logic [15:0] cfg_min_speech  = 16'd300;
	logic [15:0] cfg_end_silence = 16'd350;

	// bench state
	out_t        due_results [$];
	out_t        want_r;
	int          mismatches   = 0;
	int          cycle_cnt    = 0;
	int          src_idle_pct = 0;
	int          dst_stall_pct = 0;
	logic [31:0] gen_now = 32'd10000;

	typedef struct {
		in_t  req;
		bit   typed;
		out_t want;
	} step_t;
	step_t plan [$];

	// next result of the capture block for one accepted request
	function automatic out_t capture_next(input in_t r);
		out_t        res;
		logic [31:0] since;
		bit          full;
		bit          ended;
		res = '0;
		if (r.kind == KIND_READ) begin
			if (r.read_index < CLIP_N)
				res.read_data = clip_mem[r.read_index];
		end else if (!r.armed) begin
			frame_start = r.frame_last;
		end else begin
			// start decision on the first sample of a voiced frame
			since = r.now_ms - last_sent_at;
			if (!cap_on && frame_start && r.speech && since > {16'h0, cfg_cooldown}) begin
				cap_on = 1'b1;
				speech_acc = 0;
				fill = 0;
				for (int i = 0; i < PRE_N && fill < CLIP_N; i++) begin
					clip_mem[fill] = pre_ring[(ring_wr + i) % PRE_N];
					fill++;
				end
			end
			pre_ring[ring_wr] = r.sample;
			ring_wr = (ring_wr + 1) % PRE_N;
			if (cap_on && fill < CLIP_N) begin
				clip_mem[fill] = r.sample;
				fill++;
			end
			if (fill > clip_hi)
				clip_hi = fill;
			// frame end checks
			if (cap_on && r.frame_last) begin
				if (r.speech) begin
					speech_acc += 32'(r.frame_ms);
					if (speech_acc > 65535)
						speech_acc = 65535;
				end
				full = fill >= CLIP_N;
				since = r.now_ms - last_voiced_at;
				ended = !r.speech && speech_acc > 0 && since > {16'h0, cfg_end_silence};
				if (r.speech)
					last_voiced_at = r.now_ms;
				if (full || ended) begin
					cap_on = 1'b0;
					if (speech_acc >= cfg_min_speech && r.link_up) begin
						res.clip_ready = 1'b1;
						res.clip_length = fill[15:0];
						last_sent_at = r.now_ms;
					end
				end
			end
			frame_start = r.frame_last;
		end
		res.capturing = cap_on;
		return res;
	endfunction

	function automatic in_t smp(input logic [15:0] s, input bit sp, input bit last,
			input int fms, input logic [31:0] now, input bit arm, input bit link);
		in_t r;
		r = '0;
		r.kind = KIND_SAMPLE;
		r.sample = s;
		r.speech = sp;
		r.frame_last = last;
		r.frame_ms = fms[9:0];
		r.now_ms = now;
		r.armed = arm;
		r.link_up = link;
		return r;
	endfunction

	function automatic in_t rd(input int idx);
		in_t r;
		r = '0;
		r.kind = KIND_READ;
		r.read_index = idx[14:0];
		return r;
	endfunction

	function automatic logic [15:0] pick_sample();
		case ($urandom_range(15))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// fully random request, reads kept inside the written part of the clip
	function automatic in_t noise_req();
		logic [95:0] raw;
		in_t         r;
		raw = {$urandom, $urandom, $urandom};
		r = raw[$bits(in_t)-1:0];
		if (r.frame_ms > 10'd1000)
			r.frame_ms = 10'($urandom_range(1000));
		if (r.kind == KIND_READ) begin
			if (clip_hi == 0)
				r.kind = KIND_SAMPLE;
			else
				r.read_index = 15'($urandom_range(clip_hi - 1));
		end
		return r;
	endfunction

	// send one request and queue its expected result at acceptance
	task automatic send(input in_t r, input bit typed = 1'b0, input out_t want = '0);
		out_t predicted;
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(negedge clk);
		end
		src_valid <= 1'b1;
		src_data <= r;
		do @(posedge clk); while (!src_ready);
		predicted = capture_next(r);
		due_results.push_back(typed ? want : predicted);
	endtask

	// hold off requests until every expected result is back
	task automatic drain_results();
		@(negedge clk);
		src_valid <= 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
	endtask

	// apb write then read back
	task automatic write_reg(input int idx, input logic [15:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_AW'(idx * 4);
		pwdata <= {16'h0, val};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[15:0] !== val) begin
			$display("%0t: reg %0d readback expected %h got %h", $time, idx, val, prdata[15:0]);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_COOLDOWN:    cfg_cooldown = val;
			REG_MIN_SPEECH:  cfg_min_speech = val;
			REG_END_SILENCE: cfg_end_silence = val;
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [15:0] cool, input logic [15:0] min_sp,
			input logic [15:0] end_sil);
		write_reg(REG_COOLDOWN, cool);
		write_reg(REG_MIN_SPEECH, min_sp);
		write_reg(REG_END_SILENCE, end_sil);
	endtask

	// framed traffic with random content, plus reads and noise
	task automatic run_random(input int n);
		int         done;
		int         len;
		bit         f_speech;
		bit         f_arm;
		logic [9:0] f_ms;
		in_t        r;
		done = 0;
		f_ms = 10'd20;
		while (done < n) begin
			gen_now += 32'(f_ms);
			if ($urandom_range(29) == 0)
				gen_now += $urandom_range(80000);
			if ($urandom_range(199) == 0)
				gen_now = $urandom;
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(6, 1);
			f_speech = $urandom_range(1);
			case ($urandom_range(9))
				0: f_ms = 10'd0;
				1: f_ms = 10'd1000;
				2, 3: f_ms = 10'($urandom_range(1000));
				default: f_ms = 10'($urandom_range(40, 10));
			endcase
			f_arm = ($urandom_range(19) != 0);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(7) == 0) begin
					send(noise_req());
					done++;
				end
				r = '0;
				r.kind = KIND_SAMPLE;
				r.sample = pick_sample();
				r.speech = f_speech ^ ($urandom_range(11) == 0);
				r.frame_last = (i == len - 1);
				r.frame_ms = f_ms;
				r.now_ms = gen_now;
				r.armed = f_arm ^ ($urandom_range(49) == 0);
				r.link_up = ($urandom_range(7) != 0);
				r.read_index = 15'($urandom);
				send(r);
				done++;
				if ($urandom_range(299) == 0)
					drain_results();
			end
		end
	endtask

	// directed steps, typed results only where obvious
	initial begin
		plan.push_back('{smp(16'h7FFF, 1, 1, 1000, 32'd0, 0, 1), 1'b1, NO_RESULT});
		plan.push_back('{smp(16'h8000, 1, 1, 20, 32'd3000, 1, 1), 1'b1, NO_RESULT});
		plan.push_back('{smp(16'h0001, 1, 0, 0, 32'd3001, 1, 1), 1'b1, CAP_ON});
		plan.push_back('{smp(16'h1234, 0, 1, 1000, 32'd3001, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{rd(2047), 1'b1, out_t'({1'b0, 16'h0, 1'b1, 16'h8000})});
		plan.push_back('{rd(2048), 1'b0, NO_RESULT});
		plan.push_back('{rd(0), 1'b1, CAP_ON});
		plan.push_back('{smp(16'hFFFF, 1, 0, 0, 32'd3030, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h0100, 1, 1, 1000, 32'd3030, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h5555, 0, 1, 30, 32'd3380, 0, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'hAAAA, 0, 1, 30, 32'd3380, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h0002, 0, 1, 30, 32'd3381, 1, 0), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h0003, 1, 1, 20, 32'd3400, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h0004, 0, 1, 20, 32'd3800, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h0005, 1, 0, 0, 32'd4000, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h0006, 1, 1, 300, 32'd4000, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h0007, 0, 1, 10, 32'd4351, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h0008, 1, 1, 10, 32'd7351, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h0009, 1, 1, 10, 32'd7352, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h000A, 0, 1, 10, 32'd7500, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h000B, 1, 1, 1000, 32'hFFFF_FF00, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h000C, 0, 1, 10, 32'h0000_0100, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{smp(16'h000D, 1, 1, 10, 32'h0000_0CB9, 1, 1), 1'b0, NO_RESULT});
		plan.push_back('{rd(2049), 1'b0, NO_RESULT});
		plan.push_back('{rd(1), 1'b0, NO_RESULT});
	end

	// receiver stalls
	always @(negedge clk)
		dst_ready <= ($urandom_range(99) >= dst_stall_pct);

	// result checker
	task automatic check_field(input string name, input logic [15:0] w, input logic [15:0] a);
		if (w !== a) begin
			mismatches++;
			$display("%0t: %s expected %h got %h", $time, name, w, a);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && dst_valid && dst_ready) begin
			if (due_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result expected none got %h", $time, dst_data);
			end else begin
				want_r = due_results.pop_front();
				check_field("clip_ready", 16'(want_r.clip_ready), 16'(dst_data.clip_ready));
				check_field("clip_length", want_r.clip_length, dst_data.clip_length);
				check_field("capturing", 16'(want_r.capturing), 16'(dst_data.capturing));
				check_field("read_data", want_r.read_data, dst_data.read_data);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// main sequence
	initial begin
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		foreach (pre_ring[i])
			pre_ring[i] = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed part on reset settings
		src_idle_pct = 15;
		dst_stall_pct = 56;
		foreach (plan[k])
			send(plan[k].req, plan[k].typed, plan[k].want);
		drain_results();

		// random phases, idling swaps sides then stops
		for (int p = 0; p < 6; p++) begin
			case (p / 2)
				0: begin
					src_idle_pct = 15;
					dst_stall_pct = 56;
				end
				1: begin
					src_idle_pct = 56;
					dst_stall_pct = 15;
				end
				default: begin
					src_idle_pct = 0;
					dst_stall_pct = 0;
				end
			endcase
			case (p)
				0: set_config(16'd1000, 16'd200, 16'd300);
				1: set_config(16'd0, 16'd0, 16'd0);
				2: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
				3: set_config(16'($urandom_range(5000)), 16'($urandom_range(2000)),
					16'($urandom_range(1000)));
				4: set_config(16'd500, 16'd0, 16'hFFFF);
				default: set_config(16'($urandom), 16'($urandom), 16'($urandom));
			endcase
			run_random(292);
			drain_results();
		end
		repeat (20) @(posedge clk);

		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
rtl/vgcc_pkg.sv
rtl/vgcc_regs.sv
rtl/vgcc_ctrl.sv
rtl/vgcc_dp.sv
rtl/voice_gated_clip_capture.sv
sim/tb.sv
